// ===== design/kmcm_pkg.sv =====
// kmcm_pkg: shared types, constants and lane status for the pigment color mixer
// depends on nothing; used by kmcm_absorb, kmcm_lane, the top level and the bench
package kmcm_pkg;

  localparam int ABSORB_FRAC_BITS_DEF = 22;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int CODE_W = 8;
  localparam int LANES  = 3;
  // numerator / denominator of the absorbance ratio
  localparam int NUM_W = 20;
  localparam int DEN_W = 17;
  localparam logic [NUM_W-1:0] NUM_ZERO = NUM_W'(998001);
  localparam logic [DEN_W-1:0] DEN_ZERO = DEN_W'(2000);

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIV,
    L_MUL,
    L_ACC,
    L_SRCH,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic              idle;
    logic              done;
    logic [CODE_W-1:0] mix;
    logic              clip;
  } lane_stat_t;

endpackage

// ===== design/kmcm_absorb.sv =====
// kmcm_absorb: restoring divider giving floor((255-c)^2 * 2^F / (510c)) for one code
// depends on kmcm_pkg
module kmcm_absorb import kmcm_pkg::*; #(
  parameter int ABSORB_FRAC_BITS = ABSORB_FRAC_BITS_DEF,
  localparam int QW = 10 + ABSORB_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CODE_W-1:0] code,
  output logic              done,
  output logic [QW-1:0]     absorb
);

  localparam int NW  = NUM_W + ABSORB_FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den_in;
  logic [CODE_W-1:0] diff;
  logic [NW-1:0]    n_sh;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [CW-1:0]    cnt;
  logic             busy;

  // zero code stands for a reflectance of one thousandth
  always_comb begin
    diff   = ~code;
    num    = (code == '0) ? NUM_ZERO : NUM_W'(diff) * NUM_W'(diff);
    den_in = (code == '0) ? DEN_ZERO
                          : ({code, 9'b0} - {{(DEN_W-CODE_W-1){1'b0}}, code, 1'b0});
    trial  = {rem, n_sh[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        n_sh <= NW'(num) << ABSORB_FRAC_BITS;
        den  <= den_in;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem    <= DEN_W'(trial - {1'b0, den});
          absorb <= {absorb[QW-2:0], 1'b1};
        end else begin
          rem    <= trial[DEN_W-1:0];
          absorb <= {absorb[QW-2:0], 1'b0};
        end
        n_sh <= n_sh << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/kmcm_lane.sv =====
// kmcm_lane: one color channel: absorbance, serial weight multiply, saturating sum,
// and a binary search for the output code; depends on kmcm_pkg and kmcm_absorb
module kmcm_lane import kmcm_pkg::*; #(
  parameter int ABSORB_FRAC_BITS = ABSORB_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  localparam int WW = WEIGHT_FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CODE_W-1:0] chan,
  input  logic [WW-1:0]     weight,
  input  logic              last,
  input  logic              take,
  output lane_stat_t        stat
);

  localparam int QW  = 10 + ABSORB_FRAC_BITS;
  localparam int PW  = WW + QW;
  localparam int MCW = $clog2(WW + 1);

  lane_state_t state, state_next;

  logic              abs_start;
  logic [CODE_W-1:0] abs_code;
  logic              abs_done;
  logic [QW-1:0]     absorb;

  logic              last_r;
  logic [WW-1:0]     w_sh;
  logic [PW-1:0]     a_sh;
  logic [PW-1:0]     prod;
  logic [MCW-1:0]    mcnt;
  logic [QW-1:0]     acc;
  logic              clip;
  logic [CODE_W-1:0] res;
  logic [2:0]        bit_idx;

  logic [QW:0]       term;
  logic [QW+1:0]     sum;
  logic [CODE_W-1:0] cand;
  logic [CODE_W-1:0] res_upd;
  logic              hit;

  kmcm_absorb #(.ABSORB_FRAC_BITS(ABSORB_FRAC_BITS)) u_absorb (
    .clk    (clk),
    .rst    (rst),
    .start  (abs_start),
    .code   (abs_code),
    .done   (abs_done),
    .absorb (absorb)
  );

  always_comb begin
    term    = prod[PW-1:WEIGHT_FRAC_BITS];
    sum     = (QW+2)'(acc) + (QW+2)'(term);
    cand    = res | (CODE_W'(1) << bit_idx);
    hit     = (acc <= absorb);
    res_upd = hit ? cand : res;
  end

  always_comb begin
    state_next = state;
    abs_start  = 1'b0;
    abs_code   = chan;
    case (state)
      L_IDLE: begin
        if (start) begin
          abs_start  = 1'b1;
          state_next = L_DIV;
        end
      end
      L_DIV: begin
        if (abs_done) state_next = L_MUL;
      end
      L_MUL: begin
        if (mcnt == MCW'(WW)) state_next = L_ACC;
      end
      L_ACC: begin
        if (last_r) begin
          abs_start  = 1'b1;
          abs_code   = CODE_W'(1) << (CODE_W - 1);
          state_next = L_SRCH;
        end else begin
          state_next = L_IDLE;
        end
      end
      L_SRCH: begin
        abs_code = res_upd | (CODE_W'(1) << (bit_idx - 3'd1));
        if (abs_done) begin
          if (bit_idx == 3'd0) begin
            state_next = L_DONE;
          end else begin
            abs_start = 1'b1;
          end
        end
      end
      L_DONE: begin
        if (take) state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      clip <= 1'b0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            w_sh   <= weight;
            last_r <= last;
          end
        end
        L_DIV: begin
          a_sh <= PW'(absorb);
          prod <= '0;
          mcnt <= '0;
        end
        L_MUL: begin
          if (w_sh[0]) prod <= prod + a_sh;
          w_sh <= w_sh >> 1;
          a_sh <= a_sh << 1;
          mcnt <= mcnt + 1'b1;
        end
        L_ACC: begin
          // clip at all-ones and remember it for this mix
          if (sum[QW+1:QW] != 2'b00) begin
            acc  <= '1;
            clip <= 1'b1;
          end else begin
            acc <= sum[QW-1:0];
          end
          res     <= '0;
          bit_idx <= 3'(CODE_W - 1);
        end
        L_SRCH: begin
          if (abs_done) begin
            res     <= res_upd;
            bit_idx <= bit_idx - 3'd1;
          end
        end
        L_DONE: begin
          if (take) begin
            acc  <= '0;
            clip <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.idle = (state == L_IDLE);
  assign stat.done = (state == L_DONE);
  assign stat.mix  = res;
  assign stat.clip = clip;

endmodule

// ===== design/kubelka_munk_color_mixer.sv =====
// kubelka_munk_color_mixer: top level, three channel lanes and the merging output stage
// depends on kmcm_pkg and kmcm_lane
//
// Pigment-style RGB mixer after the single-constant Kubelka-Munk model. Each input
// item carries one color and its weight (unsigned Q1.WEIGHT_FRAC_BITS); each channel
// is turned into an absorbance (1-x)^2/(2x), x = c/255 (zero counts as 0.001), and
// weight times absorbance is added into a saturating per-channel sum. The item with
// tlast set closes the mix: each channel comes out as floor(255*R) with
// R = 1 + A - sqrt(A^2 + 2A), found exactly by a binary search over the absorbance
// of codes 1..255, and the sums are cleared. tuser flags that a sum clipped during
// the mix. Three identical lanes, one per channel, run in lockstep; one item is
// worked at a time. Each absorbance comes from a restoring divider in the lane, one
// quotient bit per cycle, and the weight multiply is shift-add. A last item adds eight
// more divisions for the search, and its result then waits in the lanes until the
// output register is free. The result sits in an output register, so the next
// item is taken while it waits; a further last item stalls only until that
// result is taken.
module kubelka_munk_color_mixer import kmcm_pkg::*; #(
  parameter int ABSORB_FRAC_BITS = ABSORB_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  localparam int WW     = WEIGHT_FRAC_BITS + 1,
  localparam int S_DW   = ((3 * CODE_W + WW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [S_DW-1:0] s_tdata,   // red, green, blue, weight from bit 0 up
  input  logic            s_tlast,   // last color of the mix
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata,   // mixed_red, mixed_green, mixed_blue from bit 0 up
  output logic [0:0]      m_tuser    // saturated
);

  lane_stat_t  stat [LANES];
  logic [CODE_W-1:0] chan [LANES];
  logic        all_idle;
  logic        all_done;
  logic        take;
  logic        accept;
  logic [WW-1:0] weight;

  // unpack the item
  assign chan[0] = s_tdata[CODE_W-1:0];
  assign chan[1] = s_tdata[2*CODE_W-1:CODE_W];
  assign chan[2] = s_tdata[3*CODE_W-1:2*CODE_W];
  assign weight  = s_tdata[3*CODE_W+WW-1:3*CODE_W];

  // lanes stay in lockstep, so all of them start and finish together
  assign all_idle = stat[0].idle & stat[1].idle & stat[2].idle;
  assign all_done = stat[0].done & stat[1].done & stat[2].done;
  assign s_tready = all_idle;
  assign accept   = s_tvalid & s_tready;
  // move a finished mix into the output register when it is free
  assign take     = all_done & (~m_tvalid | m_tready);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    kmcm_lane #(
      .ABSORB_FRAC_BITS (ABSORB_FRAC_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (accept),
      .chan   (chan[i]),
      .weight (weight),
      .last   (s_tlast),
      .take   (take),
      .stat   (stat[i])
    );
  end

  // merging stage: the three codes side by side, clip flags or-ed
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {stat[2].mix, stat[1].mix, stat[0].mix};
      m_tuser <= stat[0].clip | stat[1].clip | stat[2].clip;
    end
  end

endmodule

// ===== design/kmcm_checker.sv =====
// kmcm_checker: port-level assertions for the color mixer, bound to the top level
// depends on kubelka_munk_color_mixer ports only
module kmcm_checker #(
  parameter int S_DW = 48
) (
  input logic            clk,
  input logic            rst,
  input logic            s_tvalid,
  input logic            s_tready,
  input logic [S_DW-1:0] s_tdata,
  input logic            s_tlast,
  input logic            m_tvalid,
  input logic            m_tready,
  input logic [23:0]     m_tdata,
  input logic [0:0]      m_tuser
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after an accepted item");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a new result appears only while the input side is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

endmodule

bind kubelka_munk_color_mixer kmcm_checker #(.S_DW(S_DW)) u_kmcm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/kubelka_munk_color_mixer_check.sv =====
`timescale 1ns / 1ps
// kubelka_munk_color_mixer_check: watches both streams of the mixer, predicts the mixed
// colors and compares them; depends on kmcm_pkg and the mixer's port widths
module kubelka_munk_color_mixer_check import kmcm_pkg::*; #(
  parameter int S_DW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [S_DW-1:0] s_tdata,
  input  logic            s_tlast,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [23:0]     m_tdata,
  input  logic [0:0]      m_tuser,
  output int              fail_count,
  output int              pending
);
  localparam int AFB = ABSORB_FRAC_BITS_DEF;
  localparam int WFB = WEIGHT_FRAC_BITS_DEF;
  localparam int ACCW = 10 + AFB;
  localparam logic [ACCW-1:0] ACC_TOP = '1;

  typedef struct packed {
    logic       sat;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } mix_t;

  logic [ACCW-1:0] absorb_tab [256];
  logic [ACCW-1:0] sum_r, sum_g, sum_b;
  logic            clipped;
  mix_t            mixes_due [$];

  initial begin
    longint unsigned d;
    absorb_tab[0] = ACCW'((longint'(998001) << AFB) / 2000);
    for (int c = 1; c < 256; c++) begin
      d = 255 - c;
      absorb_tab[c] = ACCW'(((d * d) << AFB) / (510 * c));
    end
  end

  // add weight * absorbance with saturation
  function automatic logic [ACCW-1:0] add_term(input logic [ACCW-1:0] s,
      input logic [WFB:0] w, input logic [7:0] c, inout logic clip);
    logic [ACCW+WFB+1:0] t;
    t = ((ACCW+WFB+2)'(w) * absorb_tab[c]) >> WFB;
    t = t + s;
    if (t > ACC_TOP) begin
      clip = 1'b1;
      return ACC_TOP;
    end
    return ACCW'(t);
  endfunction

  // largest code whose absorbance is not below the sum
  function automatic logic [7:0] code_of(input logic [ACCW-1:0] s);
    for (int k = 255; k >= 1; k--)
      if (s <= absorb_tab[k]) return 8'(k);
    return 8'd0;
  endfunction

  always @(posedge clk) begin
    mix_t got, want;
    logic clip;
    if (rst) begin
      sum_r <= '0; sum_g <= '0; sum_b <= '0; clipped <= 1'b0;
      fail_count <= 0;
      pending <= 0;
      mixes_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        logic [ACCW-1:0] nr, ng, nb;
        clip = clipped;
        nr = add_term(sum_r, s_tdata[24 +: WFB+1], s_tdata[7:0], clip);
        ng = add_term(sum_g, s_tdata[24 +: WFB+1], s_tdata[15:8], clip);
        nb = add_term(sum_b, s_tdata[24 +: WFB+1], s_tdata[23:16], clip);
        if (s_tlast) begin
          want.r = code_of(nr); want.g = code_of(ng); want.b = code_of(nb);
          want.sat = clip;
          mixes_due.push_back(want);
          sum_r <= '0; sum_g <= '0; sum_b <= '0; clipped <= 1'b0;
        end else begin
          sum_r <= nr; sum_g <= ng; sum_b <= nb; clipped <= clip;
        end
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (mixes_due.size() == 0) begin
          $display("%0t: unexpected mix result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = mixes_due.pop_front();
          if (got !== want) begin
            $display({"%0t: mix mismatch expected r%0d g%0d b%0d sat%0d",
                      " actual r%0d g%0d b%0d sat%0d"},
                     $time, want.r, want.g, want.b, want.sat,
                     got.r, got.g, got.b, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= mixes_due.size();
    end
  end
endmodule

// ===== bench/kubelka_munk_color_mixer_test.sv =====
`timescale 1ns / 1ps
// kubelka_munk_color_mixer_test: stimulus, clock, reset and verdict for the color mixer
// depends on kmcm_pkg, kubelka_munk_color_mixer and kubelka_munk_color_mixer_check
module kubelka_munk_color_mixer_test;
  import kmcm_pkg::*;
  localparam int WW = WEIGHT_FRAC_BITS_DEF + 1;
  localparam int S_DW = ((3 * CODE_W + WW + 7) / 8) * 8;
  localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tlast = 1'b0, m_tready = 1'b0;
  logic [S_DW-1:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [23:0] m_tdata;
  logic [0:0] m_tuser;
  int fail_count, pending;
  bit calm = 1'b0;  // stretch with no idling on either side

  always #6 clk = ~clk;

  kubelka_munk_color_mixer DUT (.*);
  kubelka_munk_color_mixer_check #(.S_DW(S_DW)) checker_i (.*);

  // result side backpressure
  always @(posedge clk)
    m_tready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 9);

  task automatic send_color(input logic [7:0] r, g, b, input logic [WW-1:0] w,
                            input logic last);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DW'({w, b, g, r});
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [WW-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2: return ONE;
      default: return WW'($urandom_range(ONE));
    endcase
  endfunction

  initial begin
    int n, len, k;
    logic [WW-1:0] w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: single colors at full weight return themselves
    send_color(8'd0, 8'd255, 8'd1, ONE, 1'b1);
    send_color(8'd128, 8'd254, 8'd77, ONE, 1'b1);
    // two-color mix with weights c and 1-c
    send_color(8'd255, 8'd0, 8'd0, WW'('h4000), 1'b0);
    send_color(8'd0, 8'd0, 8'd255, ONE - WW'('h4000), 1'b1);
    // zero weight on the last item, and a lone zero-weight mix
    send_color(8'd200, 8'd50, 8'd10, ONE, 1'b0);
    send_color(8'd0, 8'd0, 8'd0, '0, 1'b1);
    send_color(8'd0, 8'd0, 8'd0, '0, 1'b1);
    // weights above one and not summing to one
    send_color(8'd0, 8'd0, 8'd0, '1, 1'b0);
    send_color(8'd255, 8'd255, 8'd255, '1, 1'b1);
    send_color(8'd30, 8'd90, 8'd170, WW'('h1000), 1'b0);
    send_color(8'd60, 8'd120, 8'd240, WW'('h2000), 1'b1);
    // accumulator overflow: black at maximum weight many times, clipping from the second item on
    for (int i = 0; i < 8; i++) send_color(8'd0, 8'd0, 8'd0, '1, 1'b0);
    send_color(8'd0, 8'd3, 8'd0, '1, 1'b1);
    // clip flag must clear for the next mix
    send_color(8'd100, 8'd100, 8'd100, ONE, 1'b1);
    // sender pause until every result is back
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    n = 0;
    k = 0;
    while (n < 2000) begin
      calm = (n >= 800 && n < 1100);
      len = $urandom_range(9) == 0 ? $urandom_range(40, 12) : $urandom_range(4, 1);
      for (int i = 0; i < len; i++) begin
        w = rand_weight();
        send_color(8'($urandom), 8'($urandom), 8'($urandom), w, i == len - 1);
        n++;
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    k = 0;
    while (pending != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== sim.f =====
design/kmcm_pkg.sv
design/kmcm_absorb.sv
design/kmcm_lane.sv
design/kubelka_munk_color_mixer.sv
design/kmcm_checker.sv
bench/kubelka_munk_color_mixer_check.sv
bench/kubelka_munk_color_mixer_test.sv
